### design/lwfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_pkg
// Shared widths, reset values, register indexes, sequencer modes and window
// slots of the wall-follow controller.
// ----------------------------------------------------------------------------
package lwfc_pkg;

    // default build parameters
    localparam int DIST_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 12;

    // fixed field widths
    localparam int DIST_FIELD_BITS = 16;
    localparam int LENGTH_BITS     = 13;
    localparam int HALF_BITS       = 10;
    localparam int SPEED_BITS      = 12;
    localparam int GAIN_BITS       = 24;
    localparam int GOAL_BITS       = 16;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int LIN_BITS        = 13;
    localparam int TURN_BITS       = 25;
    localparam int MODE_BITS       = 2;
    localparam int GAIN_FRAC_BITS  = 16;

    localparam int TURN_MAX = 16777215;
    localparam int TURN_MIN = -16777216;

    // register reset values
    localparam logic [LENGTH_BITS-1:0] SCAN_LENGTH_RST = 13'd1024;
    localparam logic [HALF_BITS-1:0]   HALF_WIDTH_RST  = 10'd10;
    localparam logic [SPEED_BITS-1:0]  DRIVE_SPEED_RST = 12'd10;
    localparam logic [GAIN_BITS-1:0]   TURN_GAIN_RST   = 24'd655;
    localparam logic [GOAL_BITS-1:0]   GOAL_DIST_RST   = 16'd4500;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_SPEED = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GOAL_DIST   = 3'd4;

    // sequencer modes
    localparam logic [MODE_BITS-1:0] MODE_FORWARD = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ARM     = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REVERSE = 2'd2;

    // window slots
    localparam logic [1:0] WIN_LEFT   = 2'd0;
    localparam logic [1:0] WIN_RIGHT  = 2'd1;
    localparam logic [1:0] WIN_CENTRE = 2'd2;

endpackage

### design/lwfc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_in_if
// Input channel: range samples and control ticks.
// ----------------------------------------------------------------------------
interface lwfc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [lwfc_pkg::DIST_FIELD_BITS-1:0] distance;
    logic                                 invalid;

    modport source (output valid, output command, output distance, output invalid,
                    input ready);
    modport sink   (input valid, input command, input distance, input invalid,
                    output ready);
endinterface

### design/lwfc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_out_if
// Output channel: one motion command per control tick.
// ----------------------------------------------------------------------------
interface lwfc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lwfc_pkg::LIN_BITS-1:0]  linear_speed;
    logic signed [lwfc_pkg::TURN_BITS-1:0] turn_rate;
    logic                                  arm_open;
    logic [lwfc_pkg::MODE_BITS-1:0]        mode;

    modport source (output valid, output linear_speed, output turn_rate,
                    output arm_open, output mode, input ready);
    modport sink   (input valid, input linear_speed, input turn_rate,
                    input arm_open, input mode, output ready);
endinterface

### design/lwfc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_div
// Bit-serial restoring divider: one quotient bit per cycle, remainder held
// in a register no wider than the divisor.
// ----------------------------------------------------------------------------
module lwfc_div #(
    parameter int SUM_BITS = 29,
    parameter int CNT_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_BITS-1:0] i_dividend,
    input  logic [CNT_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [SUM_BITS-1:0] o_quotient
);
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic [CNT_BITS-1:0]  r_rem;
    logic [SUM_BITS-1:0]  r_q;      // dividend bits out at the top, quotient in at the bottom
    logic [CNT_BITS-1:0]  r_den;
    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CNT_BITS:0]    w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_q[SUM_BITS-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(SUM_BITS);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? CNT_BITS'(w_trial - {1'b0, r_den})
                               : w_trial[CNT_BITS-1:0];
                r_q   <= {r_q[SUM_BITS-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

### design/lwfc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwfc_mul
// Bit-serial steering multiplier: signed difference times unsigned Q8.16
// gain, one gain bit per cycle, then floor shift and saturation.
// ----------------------------------------------------------------------------
module lwfc_mul #(
    parameter int DIFF_BITS = 17
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [DIFF_BITS-1:0]           i_diff,
    input  logic [lwfc_pkg::GAIN_BITS-1:0]        i_gain,
    output logic                                  o_done,
    output logic signed [lwfc_pkg::TURN_BITS-1:0] o_turn
);
    localparam int GB        = lwfc_pkg::GAIN_BITS;
    localparam int PW        = DIFF_BITS + 1 + GB;
    localparam int STEP_BITS = $clog2(GB + 1);
    localparam logic signed [PW-1:0] Q_MAX = PW'(lwfc_pkg::TURN_MAX);
    localparam logic signed [PW-1:0] Q_MIN = PW'(lwfc_pkg::TURN_MIN);

    logic signed [DIFF_BITS:0]   r_hi;
    logic [GB-1:0]               r_lo;
    logic [GB-1:0]               r_gain;
    logic signed [DIFF_BITS-1:0] r_diff;
    logic [STEP_BITS-1:0]        r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic signed [DIFF_BITS:0]   w_add;
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_q;

    // partial product only ever needs one bit more than the difference
    assign w_add = r_gain[0] ? (r_hi + {r_diff[DIFF_BITS-1], r_diff}) : r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(GB);
                r_hi   <= '0;
                r_lo   <= '0;
                r_gain <= i_gain;
                r_diff <= i_diff;
            end else if (r_busy) begin
                r_hi   <= {w_add[DIFF_BITS], w_add[DIFF_BITS:1]};
                r_lo   <= {w_add[0], r_lo[GB-1:1]};
                r_gain <= {1'b0, r_gain[GB-1:1]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_prod = $signed({r_hi, r_lo});
    assign w_q    = w_prod >>> lwfc_pkg::GAIN_FRAC_BITS;   // floor for negatives too

    always_comb begin
        if (w_q > Q_MAX) begin
            o_turn = Q_MAX[lwfc_pkg::TURN_BITS-1:0];
        end else if (w_q < Q_MIN) begin
            o_turn = Q_MIN[lwfc_pkg::TURN_BITS-1:0];
        end else begin
            o_turn = w_q[lwfc_pkg::TURN_BITS-1:0];
        end
    end

    assign o_done = r_done;
endmodule

### design/lidar_wall_follow_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_wall_follow_controller_core
// Range windows, scan averages and the forward / arm-open / reverse sequencer.
// ----------------------------------------------------------------------------
// A range sample is taken in S_IDLE and accumulated in S_SAMPLE; it produces
// no output. The last sample of a scan then runs the serial divider, which
// retires one quotient bit per cycle for each of the left, right and centre
// windows in turn; an empty window is skipped. A control tick in forward or
// reverse mode runs the serial steering multiplier (one gain bit per cycle over
// 24 gain bits) before S_TICK_OUT; in arm-open mode it goes straight to
// S_TICK_OUT. Input is taken whenever the sequencer is idle, even while an
// earlier command waits in the output register; a tick waits only for that
// register to free up.
// ----------------------------------------------------------------------------
module lidar_wall_follow_controller_core #(
    parameter int DIST_BITS  = lwfc_pkg::DIST_BITS_DEF,
    parameter int INDEX_BITS = lwfc_pkg::INDEX_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    lwfc_in_if.sink                                i_in,
    lwfc_out_if.source                             o_out,
    input  logic                                   i_cfg_we,
    input  logic [lwfc_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [lwfc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    localparam int CNT_BITS  = INDEX_BITS + 1;
    localparam int SUM_BITS  = DIST_BITS + CNT_BITS;
    localparam int LEN_BITS  = INDEX_BITS + 1;
    localparam int CW        = (lwfc_pkg::LENGTH_BITS > LEN_BITS) ?
                               lwfc_pkg::LENGTH_BITS : LEN_BITS;
    localparam int HW        = ((INDEX_BITS > lwfc_pkg::HALF_BITS) ?
                               INDEX_BITS : lwfc_pkg::HALF_BITS) + 1;
    localparam int GW        = (DIST_BITS > lwfc_pkg::GOAL_BITS) ?
                               DIST_BITS : lwfc_pkg::GOAL_BITS;
    localparam logic [CW-1:0] MAX_LEN = CW'(2 ** INDEX_BITS);

    localparam int WIN_IDX_LEFT   = 0;
    localparam int WIN_IDX_RIGHT  = 1;
    localparam int WIN_IDX_CENTRE = 2;

    typedef enum logic [2:0] {
        S_IDLE, S_SAMPLE, S_DIV_SEL, S_DIV_WAIT, S_TICK, S_MUL, S_TICK_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [lwfc_pkg::LENGTH_BITS-1:0] r_scan_length;
    logic [lwfc_pkg::HALF_BITS-1:0]   r_half_width;
    logic [lwfc_pkg::SPEED_BITS-1:0]  r_drive_speed;
    logic [lwfc_pkg::GAIN_BITS-1:0]   r_turn_gain;
    logic [lwfc_pkg::GOAL_BITS-1:0]   r_goal;

    // scan state
    logic [INDEX_BITS-1:0]            r_index;
    logic [SUM_BITS-1:0]              r_sum [3];
    logic [CNT_BITS-1:0]              r_cnt [3];
    logic [DIST_BITS-1:0]             r_avg [3];
    logic [lwfc_pkg::MODE_BITS-1:0]   r_mode;
    logic [1:0]                       r_win;

    logic [DIST_BITS-1:0]             r_dist;
    logic                             r_invalid;

    // output register
    logic                                 r_out_valid;
    logic signed [lwfc_pkg::LIN_BITS-1:0] r_lin;
    logic signed [lwfc_pkg::TURN_BITS-1:0] r_turn;
    logic                                 r_arm;
    logic [lwfc_pkg::MODE_BITS-1:0]       r_out_mode;

    // window bounds
    logic [CW-1:0]         w_len_ext;
    logic [LEN_BITS-1:0]   w_len;
    logic [HW-1:0]         w_last;
    logic [HW-1:0]         w_ctr;
    logic [HW-1:0]         w_h;
    logic [HW-1:0]         w_idx;
    logic [HW-1:0]         w_left_hi;
    logic [HW-1:0]         w_right_lo;
    logic [HW-1:0]         w_ctr_lo;
    logic [HW-1:0]         w_ctr_sum;
    logic [HW-1:0]         w_ctr_hi;
    logic [2:0]            w_hit;
    logic                  w_scan_end;

    logic [DIST_BITS+lwfc_pkg::DIST_FIELD_BITS-1:0] w_dist_ext;
    logic [GW-1:0]         w_ctr_avg;
    logic [GW-1:0]         w_goal;
    logic                  w_out_free;
    logic                  w_in_xfer;

    logic signed [DIST_BITS:0]              w_diff;
    logic signed [lwfc_pkg::LIN_BITS-1:0]   w_speed;
    logic                                   w_mul_start;
    logic                                   w_mul_done;
    logic signed [lwfc_pkg::TURN_BITS-1:0]  w_mul_turn;
    logic                                   w_div_start;
    logic                                   w_div_done;
    logic [SUM_BITS-1:0]                    w_quot;

    // effective scan length: zero acts as one, saturate at the index range
    assign w_len_ext = CW'(r_scan_length);
    always_comb begin
        if (r_scan_length == '0) begin
            w_len = LEN_BITS'(1);
        end else if (w_len_ext > MAX_LEN) begin
            w_len = MAX_LEN[LEN_BITS-1:0];
        end else begin
            w_len = w_len_ext[LEN_BITS-1:0];
        end
    end

    assign w_last     = HW'(w_len) - HW'(1);
    assign w_ctr      = HW'(w_len >> 1);
    assign w_h        = HW'(r_half_width);
    assign w_idx      = HW'(r_index);
    assign w_left_hi  = (w_h < w_last) ? w_h : w_last;
    assign w_right_lo = (w_last > w_h) ? (w_last - w_h) : '0;
    assign w_ctr_lo   = (w_ctr > w_h) ? (w_ctr - w_h) : '0;
    assign w_ctr_sum  = w_ctr + w_h;
    assign w_ctr_hi   = (w_ctr_sum < w_last) ? w_ctr_sum : w_last;

    assign w_hit[WIN_IDX_LEFT]   = (w_idx <= w_left_hi);
    assign w_hit[WIN_IDX_RIGHT]  = (w_idx >= w_right_lo) && (w_idx <= w_last);
    assign w_hit[WIN_IDX_CENTRE] = (w_idx >= w_ctr_lo) && (w_idx <= w_ctr_hi);

    // an index left past a lowered length also closes the scan
    assign w_scan_end = ((LEN_BITS'(r_index) + LEN_BITS'(1)) >= w_len);

    assign w_dist_ext = {{DIST_BITS{1'b0}}, i_in.distance};
    assign w_ctr_avg  = GW'(r_avg[lwfc_pkg::WIN_CENTRE]);
    assign w_goal     = GW'(r_goal);

    assign w_diff  = $signed({1'b0, r_avg[lwfc_pkg::WIN_LEFT]})
                   - $signed({1'b0, r_avg[lwfc_pkg::WIN_RIGHT]});
    assign w_speed = $signed({1'b0, r_drive_speed});

    assign w_in_xfer   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_mul_start = (r_state == S_TICK);
    assign w_div_start = (r_state == S_DIV_SEL) && (r_cnt[r_win] != '0);

    lwfc_mul #(
        .DIFF_BITS (DIST_BITS + 1)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_diff  (w_diff),
        .i_gain  (r_turn_gain),
        .o_done  (w_mul_done),
        .o_turn  (w_mul_turn)
    );

    lwfc_div #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum[r_win]),
        .i_divisor  (r_cnt[r_win]),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_scan_length <= lwfc_pkg::SCAN_LENGTH_RST;
            r_half_width  <= lwfc_pkg::HALF_WIDTH_RST;
            r_drive_speed <= lwfc_pkg::DRIVE_SPEED_RST;
            r_turn_gain   <= lwfc_pkg::TURN_GAIN_RST;
            r_goal        <= lwfc_pkg::GOAL_DIST_RST;
            r_index       <= '0;
            r_mode        <= lwfc_pkg::MODE_FORWARD;
            r_win         <= lwfc_pkg::WIN_LEFT;
            r_out_valid   <= 1'b0;
            for (int w = 0; w < 3; w++) begin
                r_sum[w] <= '0;
                r_cnt[w] <= '0;
                r_avg[w] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lwfc_pkg::REG_SCAN_LENGTH:
                        r_scan_length <= i_cfg_data[lwfc_pkg::LENGTH_BITS-1:0];
                    lwfc_pkg::REG_HALF_WIDTH:
                        r_half_width  <= i_cfg_data[lwfc_pkg::HALF_BITS-1:0];
                    lwfc_pkg::REG_DRIVE_SPEED:
                        r_drive_speed <= i_cfg_data[lwfc_pkg::SPEED_BITS-1:0];
                    lwfc_pkg::REG_TURN_GAIN:
                        r_turn_gain   <= i_cfg_data[lwfc_pkg::GAIN_BITS-1:0];
                    lwfc_pkg::REG_GOAL_DIST:
                        r_goal        <= i_cfg_data[lwfc_pkg::GOAL_BITS-1:0];
                    default: ;
                endcase
            end

            // in S_TICK_OUT the output register is refilled instead
            if (r_out_valid && o_out.ready && (r_state != S_TICK_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_dist    <= w_dist_ext[DIST_BITS-1:0];
                        r_invalid <= i_in.invalid;
                        if (i_in.command) begin
                            r_state <= (r_mode == lwfc_pkg::MODE_ARM) ? S_TICK_OUT : S_TICK;
                        end else begin
                            r_state <= S_SAMPLE;
                        end
                    end
                end
                S_SAMPLE: begin
                    if (!r_invalid) begin
                        for (int w = 0; w < 3; w++) begin
                            if (w_hit[w]) begin
                                r_sum[w] <= r_sum[w] + SUM_BITS'(r_dist);
                                r_cnt[w] <= r_cnt[w] + 1'b1;
                            end
                        end
                    end
                    if (w_scan_end) begin
                        r_index <= '0;
                        r_win   <= lwfc_pkg::WIN_LEFT;
                        r_state <= S_DIV_SEL;
                    end else begin
                        r_index <= r_index + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV_SEL, S_DIV_WAIT: begin
                    // empty windows keep their old average
                    if (r_state == S_DIV_SEL && r_cnt[r_win] != '0) begin
                        r_state <= S_DIV_WAIT;
                    end else if (r_state == S_DIV_SEL || w_div_done) begin
                        if (r_state == S_DIV_WAIT) begin
                            r_avg[r_win] <= w_quot[DIST_BITS-1:0];
                        end
                        r_sum[r_win] <= '0;
                        r_cnt[r_win] <= '0;
                        if (r_win == lwfc_pkg::WIN_CENTRE) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_win   <= r_win + 1'b1;
                            r_state <= S_DIV_SEL;
                        end
                    end
                end
                S_TICK: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_TICK_OUT;
                    end
                end
                S_TICK_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        case (r_mode)
                            lwfc_pkg::MODE_FORWARD: begin
                                r_lin      <= w_speed;
                                r_turn     <= w_mul_turn;
                                r_arm      <= 1'b0;
                                r_out_mode <= (w_ctr_avg > w_goal) ?
                                              lwfc_pkg::MODE_ARM : lwfc_pkg::MODE_FORWARD;
                                r_mode     <= (w_ctr_avg > w_goal) ?
                                              lwfc_pkg::MODE_ARM : lwfc_pkg::MODE_FORWARD;
                            end
                            lwfc_pkg::MODE_ARM: begin
                                r_lin      <= '0;
                                r_turn     <= '0;
                                r_arm      <= 1'b1;
                                r_out_mode <= lwfc_pkg::MODE_REVERSE;
                                r_mode     <= lwfc_pkg::MODE_REVERSE;
                            end
                            default: begin
                                r_lin      <= -w_speed;
                                r_turn     <= w_mul_turn;
                                r_arm      <= 1'b0;
                                r_out_mode <= lwfc_pkg::MODE_REVERSE;
                                r_mode     <= lwfc_pkg::MODE_REVERSE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.linear_speed = r_lin;
    assign o_out.turn_rate    = r_turn;
    assign o_out.arm_open     = r_arm;
    assign o_out.mode         = r_out_mode;
endmodule
